// File: src/nqbs_pkg.sv
package nqbs_pkg;

  localparam int IDX_W     = 5;   // row / column counters, also the board size register
  localparam int COL_W     = 4;   // one packed column in placement
  localparam int PLACE_W   = 64;
  localparam int COUNT_W   = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0]   SIZE_RESET = 5'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             toggle;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mask_cmd_t;

endpackage

// File: src/nqbs_masks.sv
module nqbs_masks
  import nqbs_pkg::*;
#(
  parameter int MAX_SIZE = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  mask_cmd_t        cmd,
  input  logic [IDX_W-1:0] test_row,
  input  logic [IDX_W-1:0] test_col,
  output logic             free
);

  localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DN    = 2 * MAX_SIZE - 1;
  localparam int DW    = $clog2(DN);
  localparam int SUM_W = IDX_W + 1;

  logic [MAX_SIZE-1:0] column_free, column_free_next;
  logic [DN-1:0]       main_free, main_free_next;
  logic [DN-1:0]       anti_free, anti_free_next;

  function automatic logic [DW-1:0] main_idx(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
    logic [SUM_W-1:0] s;
    s = SUM_W'(r) + SUM_W'(MAX_SIZE - 1) - SUM_W'(c);
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] anti_idx(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
    logic [SUM_W-1:0] s;
    s = SUM_W'(r) + SUM_W'(c);
    return s[DW-1:0];
  endfunction

  assign free = column_free[test_col[CW-1:0]] &
                main_free[main_idx(test_row, test_col)] &
                anti_free[anti_idx(test_row, test_col)];

  always_comb begin
    column_free_next = column_free;
    main_free_next   = main_free;
    anti_free_next   = anti_free;
    if (cmd.clear) begin
      column_free_next = '1;
      main_free_next   = '1;
      anti_free_next   = '1;
    end else if (cmd.toggle) begin
      column_free_next[cmd.col[CW-1:0]]            = ~column_free[cmd.col[CW-1:0]];
      main_free_next[main_idx(cmd.row, cmd.col)] = ~main_free[main_idx(cmd.row, cmd.col)];
      anti_free_next[anti_idx(cmd.row, cmd.col)] = ~anti_free[anti_idx(cmd.row, cmd.col)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_free <= '1;
      main_free   <= '1;
      anti_free   <= '1;
    end else begin
      column_free <= column_free_next;
      main_free   <= main_free_next;
      anti_free   <= anti_free_next;
    end
  end

endmodule

// File: src/n_queens_backtracking_solver.sv
// N-queens solver: depth-first backtracking over an explicit per-row column stack.
// Input channel (in_valid / in_stall, payload restart): each item asks for the
// next solution, or with restart=1 clears the search and asks for the first one.
// Output channel (out_valid / out_stall): one result per item with found,
// placement (4 bits per row, rows at or beyond the board size read zero),
// the saturating solution_number and exhausted.
// Configuration: cfg_write with cfg_data sets board_size (0 acts as 1, values
// above MAX_SIZE act as MAX_SIZE) and clears the search; write only while idle.
// Operation: the item is taken in S_IDLE, then S_SEARCH tests one column or pops
// one row at a time, and S_OUT presents the result; an exhausted search goes
// straight from S_IDLE to S_OUT. A single conflict-test and mask-toggle unit
// does all of it. One item is in flight at a time; in_stall is high from
// acceptance until the result is taken.
// The result stays on the output, unchanged, while out_stall is high.
// Reset: board_size returns to 8, the search and the count clear, no result
// is pending.
module n_queens_backtracking_solver
  import nqbs_pkg::*;
#(
  parameter int MAX_SIZE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IDX_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 found,
  output logic [PLACE_W-1:0]   placement,
  output logic [COUNT_W-1:0]   solution_number,
  output logic                 exhausted
);

  localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  state_t               state, state_next;
  logic [IDX_W-1:0]     board_size;
  logic [IDX_W-1:0]     row, row_next;
  logic [IDX_W-1:0]     col, col_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic                 done, done_next;
  logic                 found_q, found_q_next;
  logic [COL_W-1:0]     row_column [MAX_SIZE];

  logic                 rc_we;
  logic [CW-1:0]        rc_addr;
  logic [COL_W-1:0]     rc_data;

  logic [IDX_W-1:0]     n;
  logic [IDX_W-1:0]     pop_row;
  logic [COL_W-1:0]     pop_col;
  logic                 free;
  logic                 accept;
  mask_cmd_t            cmd;

  always_comb begin
    if (board_size == '0) n = IDX_W'(1);
    else if (board_size > IDX_W'(MAX_SIZE)) n = IDX_W'(MAX_SIZE);
    else n = board_size;
  end

  assign accept  = in_valid && !in_stall;
  assign pop_row = row - IDX_W'(1);
  assign pop_col = row_column[pop_row[CW-1:0]];

  nqbs_masks #(.MAX_SIZE(MAX_SIZE)) u_masks (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .test_row (row),
    .test_col (col),
    .free     (free)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!restart && done) state_next = S_OUT;
          else state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (col < n) begin
          if (free && (row + IDX_W'(1) >= n)) state_next = S_OUT;
        end else if (row == '0) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // search datapath
  always_comb begin
    row_next     = row;
    col_next     = col;
    count_next   = count;
    done_next    = done;
    found_q_next = found_q;
    rc_we        = 1'b0;
    rc_addr      = row[CW-1:0];
    rc_data      = col[COL_W-1:0];
    cmd          = '{clear: 1'b0, toggle: 1'b0, row: row, col: col};
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (restart) begin
            cmd.clear  = 1'b1;
            row_next   = '0;
            col_next   = '0;
            count_next = '0;
            done_next  = 1'b0;
          end else if (done) begin
            found_q_next = 1'b0;
          end else begin
            // full board left from the last solution: start by popping the last row
            col_next = (row == n) ? n : '0;
          end
        end
      end
      S_SEARCH: begin
        if (col < n) begin
          if (free) begin
            cmd.toggle = 1'b1;
            rc_we      = 1'b1;
            row_next   = row + IDX_W'(1);
            col_next   = '0;
            if (row + IDX_W'(1) >= n) begin
              found_q_next = 1'b1;
              if (count != COUNT_MAX) count_next = count + COUNT_W'(1);
            end
          end else begin
            col_next = col + IDX_W'(1);
          end
        end else if (row == '0) begin
          done_next    = 1'b1;
          found_q_next = 1'b0;
        end else begin
          // backtrack: lift the queen of the row above and try its next column
          cmd.toggle = 1'b1;
          cmd.row    = pop_row;
          cmd.col    = IDX_W'(pop_col);
          row_next   = pop_row;
          col_next   = IDX_W'(pop_col) + IDX_W'(1);
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
    if (cfg_write) begin
      cmd.clear  = 1'b1;
      row_next   = '0;
      count_next = '0;
      done_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      board_size <= SIZE_RESET;
      row        <= '0;
      col        <= '0;
      count      <= '0;
      done       <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state   <= state_next;
      row     <= row_next;
      col     <= col_next;
      count   <= count_next;
      done    <= done_next;
      found_q <= found_q_next;
      if (cfg_write) board_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rc_we) row_column[rc_addr] <= rc_data;
  end

  always_comb begin
    placement = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      if (found_q && (IDX_W'(i) < n)) placement[COL_W*i +: COL_W] = row_column[i];
    end
  end

  assign in_stall        = (state != S_IDLE);
  assign out_valid       = (state == S_OUT);
  assign found           = found_q;
  assign solution_number = count;
  assign exhausted       = done;

endmodule
